// ===== design/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg: shared constants for the euclidean rhythm pattern generator
// Field widths of the request and response channels, the step limit and the internal widths derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

package erp_pkg;

   // largest step count a pattern may use (2..64)
   localparam int MAX_STEPS = 64;

   // channel field widths
   localparam int LEN_W     = 7;
   localparam int ROT_W     = 16;
   localparam int PATTERN_W = 64;

   // step position inside a pattern
   localparam int POS_W = $clog2(MAX_STEPS);

   // shared add/compare unit works one bit wider than a step count
   localparam int SUM_W = LEN_W + 1;

   // sequencer counter: must hold the rotation bit index and a step count
   localparam int CNT_W = (LEN_W > $clog2(ROT_W)) ? LEN_W : $clog2(ROT_W);

endpackage : erp_pkg

`default_nettype wire

// ===== design/erp_req_if.sv =====
// ----------------------------------------------------------------------------
// erp_req_if: request channel of the rhythm pattern generator
// Valid/ready channel carrying step count, pulse count and rotation.
// ----------------------------------------------------------------------------
`default_nettype none

interface erp_req_if import erp_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [LEN_W-1:0]        step_count;
   logic [LEN_W-1:0]        pulse_count;
   logic signed [ROT_W-1:0] rotation_offset;

   modport source (output valid, output step_count, output pulse_count,
                   output rotation_offset, input ready);
   modport sink   (input valid, input step_count, input pulse_count,
                   input rotation_offset, output ready);

endinterface : erp_req_if

`default_nettype wire

// ===== design/erp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// erp_rsp_if: response channel of the rhythm pattern generator
// Valid/ready channel carrying the pattern word and its length.
// ----------------------------------------------------------------------------
`default_nettype none

interface erp_rsp_if import erp_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [PATTERN_W-1:0] pattern_bits;
   logic [LEN_W-1:0]     pattern_length;

   modport source (output valid, output pattern_bits, output pattern_length,
                   input ready);
   modport sink   (input valid, input pattern_bits, input pattern_length,
                   output ready);

endinterface : erp_rsp_if

`default_nettype wire

// ===== design/euclidean_rhythm_pattern.sv =====
// ----------------------------------------------------------------------------
// euclidean_rhythm_pattern: Bresenham-style euclidean rhythm generator
//
// Usage:
//   req_if (sink) takes one request per transfer: step_count, pulse_count
//   and a signed rotation_offset. Steps saturate to 1..MAX_STEPS, pulses
//   to 0..steps. rsp_if (source) returns one transfer per request with the
//   64-bit pattern (bit j = step j, bits at or above the length are zero)
//   and the step count in use.
//   Operation, with n the saturated step count: the rotation is reduced
//   modulo n one bit per cycle, the accumulator then runs over the n
//   steps one step per cycle, and the pattern then moves into the output
//   register. A new request is taken only once the pattern has moved to
//   the output register. The remainder and the accumulator share the
//   single add/compare unit, so they run one after the other.
//   req_if.ready is high only while the sequencer is idle. A finished
//   response waits in the output register, and the next request is taken
//   meanwhile; if the receiver still stalls when the following pattern is
//   done, the sequencer holds that pattern until the register frees up.
//   Reset (synchronous) returns the sequencer to idle and drops any
//   pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_rhythm_pattern import erp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   erp_req_if.sink   req_if,
   erp_rsp_if.source rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MOD  = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     n_ff, n_in;
   logic [LEN_W-1:0]     k_ff, k_in;
   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ROT_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PATTERN_W-1:0] bits_ff, bits_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PATTERN_W-1:0] rsp_bits_ff, rsp_bits_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic                 req_take;
   logic [LEN_W-1:0]     n_sat;
   logic [LEN_W-1:0]     k_sat;
   logic [SUM_W-1:0]     unit_a;
   logic [SUM_W-1:0]     unit_diff;
   logic                 unit_ge;
   logic [SUM_W-1:0]     unit_res;
   logic [LEN_W-1:0]     rot_neg;
   logic                 pos_wrap;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.pattern_bits   = rsp_bits_ff;
   assign rsp_if.pattern_length = rsp_len_ff;

   // saturate the requested counts
   always_comb begin
      if (req_if.step_count == '0) begin
         n_sat = LEN_W'(1);
      end else if (req_if.step_count > LEN_W'(MAX_STEPS)) begin
         n_sat = LEN_W'(MAX_STEPS);
      end else begin
         n_sat = req_if.step_count;
      end
      k_sat = (req_if.pulse_count > n_sat) ? n_sat : req_if.pulse_count;
   end

   // shared add/compare unit: remainder bit step or accumulator step
   always_comb begin
      if (state_ff == ST_MOD) begin
         unit_a = SUM_W'({rem_ff, mag_ff[ROT_W-1]});
      end else begin
         unit_a = SUM_W'(rem_ff) + SUM_W'(k_ff);
      end
      unit_diff = unit_a - SUM_W'(n_ff);
      unit_ge   = !unit_diff[SUM_W-1];
      unit_res  = unit_ge ? unit_diff : unit_a;
   end

   // negative rotation maps to n minus its magnitude remainder
   assign rot_neg  = n_ff - LEN_W'(unit_res);
   assign pos_wrap = (LEN_W'(pos_ff) == n_ff - LEN_W'(1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_len_in   = rsp_len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // latch the request and start the remainder
            if (req_take) begin
               n_in     = n_sat;
               k_in     = k_sat;
               neg_in   = req_if.rotation_offset[ROT_W-1];
               mag_in   = req_if.rotation_offset[ROT_W-1] ?
                          ROT_W'(-req_if.rotation_offset) :
                          ROT_W'(req_if.rotation_offset);
               rem_in   = '0;
               pos_in   = '0;
               bits_in  = '0;
               cnt_in   = CNT_W'(ROT_W - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // one rotation bit per cycle into the remainder
            rem_in = unit_res[POS_W-1:0];
            mag_in = {mag_ff[ROT_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (neg_ff && (unit_res != '0)) begin
                  pos_in = rot_neg[POS_W-1:0];
               end else begin
                  pos_in = unit_res[POS_W-1:0];
               end
               rem_in   = '0;
               cnt_in   = CNT_W'(n_ff - LEN_W'(1));
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // advance the accumulator one step, mark hits at rotated position
            rem_in = unit_res[POS_W-1:0];
            if (unit_ge) begin
               bits_in[pos_ff] = 1'b1;
            end
            pos_in = pos_wrap ? '0 : pos_ff + POS_W'(1);
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = bits_ff;
               rsp_len_in   = n_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      bits_ff     <= bits_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // accumulator stays below the step count while stepping
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (LEN_W'(rem_ff) < n_ff))
      else $error("accumulator out of range");

   // rotated position stays inside the pattern
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (LEN_W'(pos_ff) < n_ff))
      else $error("step position out of range");

   // a request starts the remainder with a cleared pattern
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_MOD) && (bits_ff == '0) && (rem_ff == '0))
      else $error("request did not start cleanly");

   // a loaded response never exceeds its length or the step limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_len_ff != '0) && (rsp_len_ff <= LEN_W'(MAX_STEPS))
                       && ((rsp_bits_ff >> rsp_len_ff) == '0))
      else $error("response length or pattern out of range");

   // a stalled response is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> rsp_valid_ff && $stable(rsp_bits_ff))
      else $error("pending response overwritten");

endmodule : euclidean_rhythm_pattern

`default_nettype wire
